@@ rtl/pia_pkg.sv @@
// pia_pkg: shared constants, types and helper functions of the page id allocator
// used by pia_ctrl, pia_dp and page_id_allocator; depends on nothing

package pia_pkg;

    localparam int MaxPages = 1024;
    localparam int IdW      = 11;
    localparam int WordW    = 32;
    localparam int BitAw    = $clog2(WordW);
    localparam int NumWords = MaxPages / WordW;
    localparam int WordAw   = $clog2(NumWords);
    localparam int MapAw    = $clog2(MaxPages);

    localparam logic [IdW-1:0]        CapReset = IdW'(100);
    localparam logic [IdW-1:0]        CapMax   = IdW'(MaxPages);
    localparam logic signed [IdW-1:0] NoId     = '1;

    typedef logic [WordW-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LO_SCAN,
        ST_GROW,
        ST_LO_SCAN2,
        ST_ALLOC_WR,
        ST_REL_CHK,
        ST_HI_SCAN,
        ST_RPT_FAIL,
        ST_RPT_OK,
        ST_RPT_GRANT
    } pia_state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_LO_INIT,
        OP_LO_SCAN,
        OP_GROW,
        OP_ALLOC_WR,
        OP_REL_RD,
        OP_REL_WR,
        OP_HI_SCAN,
        OP_REPORT
    } pia_op_t;

    typedef struct packed {
        pia_op_t op;
        logic    rpt_ok;
        logic    rpt_grant;
    } pia_cmd_t;

    typedef struct packed {
        logic mode_rel;
        logic id_neg;
        logic id_oob;
        logic fail;
        logic bit_set;
        logic lo_found;
        logic lo_exhausted;
        logic hi_done;
        logic max_is_id;
    } pia_stat_t;

    function automatic logic [IdW-1:0] clamp_cap(logic [IdW-1:0] v);
        logic [IdW-1:0] r;
        r = v;
        if (v == '0)
            r = IdW'(1);
        else if (v > CapMax)
            r = CapMax;
        return r;
    endfunction

    function automatic logic [BitAw-1:0] lowest_one(word_t w);
        logic [BitAw-1:0] idx;
        idx = '0;
        for (int i = WordW - 1; i >= 0; i--)
            if (w[i])
                idx = BitAw'(i);
        return idx;
    endfunction

    function automatic logic [BitAw-1:0] highest_one(word_t w);
        logic [BitAw-1:0] idx;
        idx = '0;
        for (int i = 0; i < WordW; i++)
            if (w[i])
                idx = BitAw'(i);
        return idx;
    endfunction

endpackage

@@ rtl/page_id_allocator.sv @@
// page_id_allocator: top level of the lowest-free page id allocator
// depends on pia_pkg, pia_ctrl (sequencer) and pia_dp (bitmap datapath)
//
//  channel   handshake            payload
//  -------   ---------            -------
//  request   start, busy          mode, page_id, write_failed
//  result    done (1-cycle strobe) ok, granted_id, highest_allocated, capacity
//  config    cfg_we               cfg_wdata (initial_capacity)
//
// a request transaction is taken at a clock edge with start high and busy low
// the bitmap is a 32 x 32 memory with one read port, scanned one word per cycle;
//   allocate scans words below capacity, doubling it and scanning again if none is free;
//   release clears the id's bit if set, and rescans downward when the highest id is freed
// rows carry valid bits cleared by reset, so there is no clearing pass after reset
// done is high for exactly one cycle per transaction; the receiver cannot stall it
// cfg_we loads capacity (0 reads as 1, above 1024 as 1024); write only while idle

module page_id_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // config
    input  logic                          cfg_we,
    input  logic [pia_pkg::IdW-1:0]       cfg_wdata,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic signed [pia_pkg::IdW-1:0] page_id,
    input  logic                          write_failed,
    // result
    output logic                          done,
    output logic                          ok,
    output logic signed [pia_pkg::IdW-1:0] granted_id,
    output logic signed [pia_pkg::IdW-1:0] highest_allocated,
    output logic [pia_pkg::IdW-1:0]       capacity
);

    // command and status between sequencer and datapath
    pia_pkg::pia_cmd_t  cmd;
    pia_pkg::pia_stat_t stat;

    pia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pia_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .mode              (mode),
        .page_id           (page_id),
        .write_failed      (write_failed),
        .cmd               (cmd),
        .stat              (stat),
        .done              (done),
        .ok                (ok),
        .granted_id        (granted_id),
        .highest_allocated (highest_allocated),
        .capacity          (capacity)
    );

endmodule

@@ rtl/pia_ctrl.sv @@
// pia_ctrl: sequencing state machine of the page id allocator
// depends on pia_pkg; drives pia_dp through pia_cmd_t, reads pia_stat_t

module pia_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pia_pkg::pia_stat_t stat,
    output pia_pkg::pia_cmd_t cmd,
    output logic              busy
);

    pia_pkg::pia_state_t state_reg;
    pia_pkg::pia_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pia_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pia_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = pia_pkg::ST_DISPATCH;
            end
            pia_pkg::ST_DISPATCH:
            begin
                if (!stat.mode_rel)
                    state_next = pia_pkg::ST_LO_SCAN;
                else if (stat.id_neg)
                    state_next = pia_pkg::ST_RPT_FAIL;
                else if (stat.id_oob)
                    state_next = pia_pkg::ST_RPT_OK;
                else
                    state_next = pia_pkg::ST_REL_CHK;
            end
            pia_pkg::ST_LO_SCAN:
            begin
                if (stat.lo_found)
                    state_next = stat.fail ? pia_pkg::ST_RPT_FAIL : pia_pkg::ST_ALLOC_WR;
                else if (stat.lo_exhausted)
                    state_next = pia_pkg::ST_GROW;
            end
            pia_pkg::ST_GROW:
            begin
                state_next = pia_pkg::ST_LO_SCAN2;
            end
            pia_pkg::ST_LO_SCAN2:
            begin
                if (stat.lo_found)
                    state_next = stat.fail ? pia_pkg::ST_RPT_FAIL : pia_pkg::ST_ALLOC_WR;
                else if (stat.lo_exhausted)
                    state_next = pia_pkg::ST_RPT_FAIL;
            end
            pia_pkg::ST_ALLOC_WR:
            begin
                state_next = pia_pkg::ST_RPT_GRANT;
            end
            pia_pkg::ST_REL_CHK:
            begin
                if (!stat.bit_set)
                    state_next = pia_pkg::ST_RPT_OK;
                else if (stat.fail)
                    state_next = pia_pkg::ST_RPT_FAIL;
                else if (stat.max_is_id)
                    state_next = pia_pkg::ST_HI_SCAN;
                else
                    state_next = pia_pkg::ST_RPT_OK;
            end
            pia_pkg::ST_HI_SCAN:
            begin
                if (stat.hi_done)
                    state_next = pia_pkg::ST_RPT_OK;
            end
            pia_pkg::ST_RPT_FAIL,
            pia_pkg::ST_RPT_OK,
            pia_pkg::ST_RPT_GRANT:
            begin
                state_next = pia_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pia_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.op        = pia_pkg::OP_NOP;
        cmd.rpt_ok    = 1'b0;
        cmd.rpt_grant = 1'b0;
        busy          = 1'b1;
        case (state_reg)
            pia_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                    cmd.op = pia_pkg::OP_ACCEPT;
            end
            pia_pkg::ST_DISPATCH:
            begin
                if (!stat.mode_rel)
                    cmd.op = pia_pkg::OP_LO_INIT;
                else if (!stat.id_neg && !stat.id_oob)
                    cmd.op = pia_pkg::OP_REL_RD;
            end
            pia_pkg::ST_LO_SCAN,
            pia_pkg::ST_LO_SCAN2:
            begin
                cmd.op = pia_pkg::OP_LO_SCAN;
            end
            pia_pkg::ST_GROW:
            begin
                cmd.op = pia_pkg::OP_GROW;
            end
            pia_pkg::ST_ALLOC_WR:
            begin
                cmd.op = pia_pkg::OP_ALLOC_WR;
            end
            pia_pkg::ST_REL_CHK:
            begin
                if (stat.bit_set && !stat.fail)
                    cmd.op = pia_pkg::OP_REL_WR;
            end
            pia_pkg::ST_HI_SCAN:
            begin
                cmd.op = pia_pkg::OP_HI_SCAN;
            end
            pia_pkg::ST_RPT_FAIL:
            begin
                cmd.op = pia_pkg::OP_REPORT;
            end
            pia_pkg::ST_RPT_OK:
            begin
                cmd.op     = pia_pkg::OP_REPORT;
                cmd.rpt_ok = 1'b1;
            end
            pia_pkg::ST_RPT_GRANT:
            begin
                cmd.op        = pia_pkg::OP_REPORT;
                cmd.rpt_ok    = 1'b1;
                cmd.rpt_grant = 1'b1;
            end
            default:
            begin
                cmd.op = pia_pkg::OP_NOP;
            end
        endcase
    end

endmodule

@@ rtl/pia_dp.sv @@
// pia_dp: bitmap memory, capacity and highest-id registers, word scan and result registers
// depends on pia_pkg; commanded by pia_ctrl

module pia_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pia_pkg::IdW-1:0]       cfg_wdata,
    input  logic                          mode,
    input  logic signed [pia_pkg::IdW-1:0] page_id,
    input  logic                          write_failed,
    input  pia_pkg::pia_cmd_t             cmd,
    output pia_pkg::pia_stat_t            stat,
    output logic                          done,
    output logic                          ok,
    output logic signed [pia_pkg::IdW-1:0] granted_id,
    output logic signed [pia_pkg::IdW-1:0] highest_allocated,
    output logic [pia_pkg::IdW-1:0]       capacity
);

    // bitmap store, one row per word, rows never written read as zero
    pia_pkg::word_t mem [pia_pkg::NumWords];

    logic [pia_pkg::NumWords-1:0]    row_vld_reg;
    pia_pkg::word_t                  rdata_reg;
    logic                            rvld_reg;

    logic [pia_pkg::IdW-1:0]         cap_reg;
    logic signed [pia_pkg::IdW-1:0]  max_reg;

    logic                            mode_reg;
    logic signed [pia_pkg::IdW-1:0]  id_reg;
    logic                            fail_reg;

    logic [pia_pkg::WordAw-1:0]      ptr_reg;
    logic [pia_pkg::WordAw-1:0]      chk_word_reg;
    logic                            chk_vld_reg;
    logic [pia_pkg::MapAw-1:0]       pick_reg;
    pia_pkg::word_t                  hold_reg;

    logic                            done_reg;
    logic                            ok_reg;
    logic signed [pia_pkg::IdW-1:0]  grant_reg;
    logic signed [pia_pkg::IdW-1:0]  high_reg;
    logic [pia_pkg::IdW-1:0]         capo_reg;

    pia_pkg::word_t                  eff_word;
    logic [pia_pkg::IdW-1:0]         capm1;
    logic [pia_pkg::WordAw-1:0]      last_word;
    logic [pia_pkg::BitAw-1:0]       rem_bits;
    pia_pkg::word_t                  lim_mask;
    pia_pkg::word_t                  free_bits;
    logic                            any_free;
    logic [pia_pkg::WordAw-1:0]      id_word;
    logic [pia_pkg::BitAw-1:0]       id_bit;
    logic                            mem_re;
    logic                            mem_we;
    logic [pia_pkg::WordAw-1:0]      raddr;
    logic [pia_pkg::WordAw-1:0]      waddr;
    pia_pkg::word_t                  wdata;
    logic signed [pia_pkg::IdW-1:0]  pick_id;
    logic signed [pia_pkg::IdW-1:0]  top_id;
    logic [pia_pkg::IdW-1:0]         cap_grown;

    assign eff_word  = rvld_reg ? rdata_reg : '0;
    assign capm1     = cap_reg - pia_pkg::IdW'(1);
    assign last_word = capm1[pia_pkg::BitAw +: pia_pkg::WordAw];
    assign rem_bits  = capm1[pia_pkg::BitAw-1:0];

    // ids at or above capacity are masked off in the last word
    assign lim_mask  = (chk_word_reg == last_word)
                     ? ({pia_pkg::WordW{1'b1}} >> (pia_pkg::BitAw'(pia_pkg::WordW - 1) - rem_bits))
                     : {pia_pkg::WordW{1'b1}};
    assign free_bits = ~eff_word & lim_mask;
    assign any_free  = |free_bits;

    assign id_word   = id_reg[pia_pkg::BitAw +: pia_pkg::WordAw];
    assign id_bit    = id_reg[pia_pkg::BitAw-1:0];

    assign pick_id   = pia_pkg::IdW'(pick_reg);
    assign top_id    = pia_pkg::IdW'({chk_word_reg, pia_pkg::highest_one(eff_word)});
    assign cap_grown = (cap_reg >= (pia_pkg::CapMax >> 1)) ? pia_pkg::CapMax
                                                            : (cap_reg << 1);

    assign stat.mode_rel     = mode_reg;
    assign stat.id_neg       = id_reg[pia_pkg::IdW-1];
    assign stat.id_oob       = !id_reg[pia_pkg::IdW-1] && ($unsigned(id_reg) >= pia_pkg::CapMax);
    assign stat.fail         = fail_reg;
    assign stat.bit_set      = eff_word[id_bit];
    assign stat.lo_found     = chk_vld_reg && any_free;
    assign stat.lo_exhausted = chk_vld_reg && !any_free && (chk_word_reg == last_word);
    assign stat.hi_done      = chk_vld_reg && ((|eff_word) || (chk_word_reg == '0));
    assign stat.max_is_id    = (max_reg == id_reg);

    assign mem_re = (cmd.op == pia_pkg::OP_LO_SCAN) || (cmd.op == pia_pkg::OP_HI_SCAN)
                 || (cmd.op == pia_pkg::OP_REL_RD);
    assign mem_we = (cmd.op == pia_pkg::OP_ALLOC_WR) || (cmd.op == pia_pkg::OP_REL_WR);
    assign raddr  = (cmd.op == pia_pkg::OP_REL_RD) ? id_word : ptr_reg;
    assign waddr  = (cmd.op == pia_pkg::OP_ALLOC_WR) ? pick_reg[pia_pkg::BitAw +: pia_pkg::WordAw]
                                                     : id_word;
    assign wdata  = (cmd.op == pia_pkg::OP_ALLOC_WR)
                  ? (hold_reg | (pia_pkg::word_t'(1) << pick_reg[pia_pkg::BitAw-1:0]))
                  : (eff_word & ~(pia_pkg::word_t'(1) << id_bit));

    // memory array
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rvld_reg    <= 1'b0;
            cap_reg     <= pia_pkg::clamp_cap(pia_pkg::CapReset);
            max_reg     <= pia_pkg::NoId;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == pia_pkg::OP_REPORT);
            if (mem_re)
                rvld_reg <= row_vld_reg[raddr];
            if (mem_we)
                row_vld_reg[waddr] <= 1'b1;
            if (cfg_we)
                cap_reg <= pia_pkg::clamp_cap(cfg_wdata);
            case (cmd.op)
                pia_pkg::OP_LO_INIT:
                begin
                    chk_vld_reg <= 1'b0;
                end
                pia_pkg::OP_GROW:
                begin
                    cap_reg     <= cap_grown;
                    chk_vld_reg <= 1'b0;
                end
                pia_pkg::OP_REL_WR:
                begin
                    chk_vld_reg <= 1'b0;
                end
                pia_pkg::OP_LO_SCAN:
                begin
                    chk_vld_reg <= 1'b1;
                end
                pia_pkg::OP_HI_SCAN:
                begin
                    chk_vld_reg <= 1'b1;
                    if (stat.hi_done)
                        max_reg <= (|eff_word) ? top_id : pia_pkg::NoId;
                end
                pia_pkg::OP_ALLOC_WR:
                begin
                    if (pick_id > max_reg)
                        max_reg <= pick_id;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pia_pkg::OP_ACCEPT:
            begin
                mode_reg <= mode;
                id_reg   <= page_id;
                fail_reg <= write_failed;
            end
            pia_pkg::OP_LO_INIT,
            pia_pkg::OP_GROW:
            begin
                ptr_reg <= '0;
            end
            pia_pkg::OP_REL_WR:
            begin
                ptr_reg <= '1;
            end
            pia_pkg::OP_LO_SCAN:
            begin
                ptr_reg      <= ptr_reg + pia_pkg::WordAw'(1);
                chk_word_reg <= ptr_reg;
                if (stat.lo_found)
                begin
                    pick_reg <= {chk_word_reg, pia_pkg::lowest_one(free_bits)};
                    hold_reg <= eff_word;
                end
            end
            pia_pkg::OP_HI_SCAN:
            begin
                ptr_reg      <= ptr_reg - pia_pkg::WordAw'(1);
                chk_word_reg <= ptr_reg;
            end
            pia_pkg::OP_REPORT:
            begin
                ok_reg    <= cmd.rpt_ok;
                grant_reg <= cmd.rpt_grant ? pick_id : pia_pkg::NoId;
                high_reg  <= max_reg;
                capo_reg  <= cap_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done              = done_reg;
    assign ok                = ok_reg;
    assign granted_id        = grant_reg;
    assign highest_allocated = high_reg;
    assign capacity          = capo_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_grant_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (grant_reg != pia_pkg::NoId)) |-> ($unsigned(grant_reg) < capo_reg))
        else $error("granted id not below capacity");

    a_grant_le_high: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (grant_reg != pia_pkg::NoId)) |-> (grant_reg <= high_reg))
        else $error("granted id above highest allocated id");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (grant_reg != pia_pkg::NoId)) |-> ok_reg)
        else $error("id granted on a failed transaction");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg != '0) && (cap_reg <= pia_pkg::CapMax))
        else $error("capacity out of range");

endmodule

@@ bench/page_id_allocator_test.sv @@
// page_id_allocator_test: self-checking bench for the page id allocator
// drives allocate and release transactions plus capacity writes, predicts every result
// depends on pia_pkg and page_id_allocator
`timescale 1ns / 1ps

module page_id_allocator_test;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;
    localparam int   STALL_LIMIT  = 4000;   // cycles with no transaction on either side
    localparam int   DRAIN_CYCLES = 100;
    localparam int   RANDOM_ITEMS = 650;
    localparam int   MAX_PAGES    = pia_pkg::MaxPages;

    typedef logic signed [pia_pkg::IdW-1:0] id_t;
    typedef logic [pia_pkg::IdW-1:0]        cap_t;

    localparam id_t  NO_ID        = pia_pkg::NoId;

    typedef struct packed {
        logic ok;
        id_t  granted;
        id_t  highest;
        cap_t cap;
    } outcome_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // config rows carry the capacity value in the id column
    typedef struct packed {
        row_kind_t kind;
        logic      rel;
        id_t       id;
        logic      wf;
        bit        typed;
        outcome_t  exp;
    } stim_row_t;

    localparam int NUM_ROWS = 24;

    // directed table: typed expectations only where the value is obvious
    localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        // after reset: negative ids, unallocated ids
        '{ROW_REQ, MODE_RELEASE, NO_ID,   1'b0, 1'b1, '{1'b0, NO_ID, NO_ID, 11'd100}},
        '{ROW_REQ, MODE_RELEASE, 11'h400, 1'b1, 1'b1, '{1'b0, NO_ID, NO_ID, 11'd100}}, // -1024
        '{ROW_REQ, MODE_RELEASE, 11'h3FF, 1'b1, 1'b1, '{1'b1, NO_ID, NO_ID, 11'd100}},
        // first grants and a failed write
        '{ROW_REQ, MODE_ALLOC,   11'h000, 1'b0, 1'b1, '{1'b1, 11'd0, 11'd0, 11'd100}},
        '{ROW_REQ, MODE_ALLOC,   11'h000, 1'b1, 1'b1, '{1'b0, NO_ID, 11'd0, 11'd100}},
        '{ROW_REQ, MODE_ALLOC,   NO_ID,   1'b0, 1'b1, '{1'b1, 11'd1, 11'd1, 11'd100}},
        '{ROW_REQ, MODE_ALLOC,   11'h3FF, 1'b0, 1'b1, '{1'b1, 11'd2, 11'd2, 11'd100}},
        // release of the highest id, failed and then good
        '{ROW_REQ, MODE_RELEASE, 11'd2,   1'b1, 1'b1, '{1'b0, NO_ID, 11'd2, 11'd100}},
        '{ROW_REQ, MODE_RELEASE, 11'd2,   1'b0, 1'b1, '{1'b1, NO_ID, 11'd1, 11'd100}},
        '{ROW_REQ, MODE_RELEASE, 11'd0,   1'b0, 1'b1, '{1'b1, NO_ID, 11'd1, 11'd100}},
        '{ROW_REQ, MODE_RELEASE, 11'd1,   1'b0, 1'b1, '{1'b1, NO_ID, NO_ID, 11'd100}},
        // zero capacity reads as one, then doublings
        '{ROW_CFG, MODE_ALLOC,   11'h000, 1'b0, 1'b0, '0},
        '{ROW_REQ, MODE_ALLOC,   11'h000, 1'b0, 1'b1, '{1'b1, 11'd0, 11'd0, 11'd1}},
        '{ROW_REQ, MODE_ALLOC,   11'h000, 1'b0, 1'b1, '{1'b1, 11'd1, 11'd1, 11'd2}},
        '{ROW_REQ, MODE_ALLOC,   11'h000, 1'b1, 1'b1, '{1'b0, NO_ID, 11'd1, 11'd4}},
        '{ROW_REQ, MODE_ALLOC,   11'h000, 1'b0, 1'b0, '0},
        // capacity above the maximum saturates
        '{ROW_CFG, MODE_ALLOC,   11'h7FF, 1'b0, 1'b0, '0},
        '{ROW_REQ, MODE_ALLOC,   11'h2AA, 1'b0, 1'b0, '0},
        '{ROW_CFG, MODE_ALLOC,   11'h400, 1'b0, 1'b0, '0},
        '{ROW_REQ, MODE_RELEASE, 11'h3FF, 1'b0, 1'b0, '0},
        // shrink below allocated ids, release one above the capacity, grow again
        '{ROW_CFG, MODE_ALLOC,   11'h002, 1'b0, 1'b0, '0},
        '{ROW_REQ, MODE_RELEASE, 11'd3,   1'b0, 1'b0, '0},
        '{ROW_REQ, MODE_ALLOC,   11'h555, 1'b0, 1'b0, '0},
        '{ROW_REQ, MODE_ALLOC,   11'h555, 1'b1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cap_t cfg_wdata;
    logic start;
    logic busy;
    logic mode;
    id_t  page_id;
    logic write_failed;
    logic done;
    logic ok;
    id_t  granted_id;
    id_t  highest_allocated;
    cap_t capacity;

    // predicted allocator state
    logic [MAX_PAGES-1:0] used_map;
    cap_t                 cur_cap;
    id_t                  top_id;

    outcome_t awaited_outcomes[$];
    outcome_t oldest_outcome;
    int       mismatches   = 0;
    int       quiet_cycles = 0;

    page_id_allocator i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .page_id           (page_id),
        .write_failed      (write_failed),
        .done              (done),
        .ok                (ok),
        .granted_id        (granted_id),
        .highest_allocated (highest_allocated),
        .capacity          (capacity)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // register value to usable capacity: 0 reads as 1, anything above the map size saturates
    function automatic cap_t fold_capacity(input cap_t v);
        if (v == '0)
            return cap_t'(1);
        if (int'(v) > MAX_PAGES)
            return cap_t'(MAX_PAGES);
        return v;
    endfunction

    function automatic int lowest_free(input cap_t limit);
        for (int i = 0; i < int'(limit) && i < MAX_PAGES; i++)
            if (!used_map[i])
                return i;
        return -1;
    endfunction

    // applies one transaction to the predicted state and returns its result
    task automatic compute_outcome(input logic rel, input id_t id, input logic wf,
                                   output outcome_t r);
        int pick;
        r.ok      = 1'b0;
        r.granted = NO_ID;
        if (rel == MODE_ALLOC)
        begin
            pick = lowest_free(cur_cap);
            if (pick < 0)
            begin
                // doubling stays even if the grant then fails
                if (int'(cur_cap) * 2 > MAX_PAGES)
                    cur_cap = cap_t'(MAX_PAGES);
                else
                    cur_cap = cap_t'(int'(cur_cap) * 2);
                pick = lowest_free(cur_cap);
            end
            if (pick >= 0 && !wf)
            begin
                used_map[pick] = 1'b1;
                if (pick > int'(top_id))
                    top_id = id_t'(pick);
                r.granted = id_t'(pick);
                r.ok      = 1'b1;
            end
        end
        else if (id < 0)
            r.ok = 1'b0;
        else if (!used_map[int'(id)])
            r.ok = 1'b1;                // nothing to free, write failure ignored
        else if (wf)
            r.ok = 1'b0;
        else
        begin
            used_map[int'(id)] = 1'b0;
            if (top_id == id)
            begin
                top_id = NO_ID;
                for (int i = MAX_PAGES - 1; i >= 0 && top_id == NO_ID; i--)
                    if (used_map[i])
                        top_id = id_t'(i);
            end
            r.ok = 1'b1;
        end
        r.highest = top_id;
        r.cap     = cur_cap;
    endtask

    // holds the request until the block takes it; start is left high for back-to-back issue
    task automatic send_request(input logic rel, input id_t id, input logic wf,
                                input bit typed, input outcome_t typed_exp);
        outcome_t predicted;
        start        <= 1'b1;
        mode         <= rel;
        page_id      <= id;
        write_failed <= wf;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        compute_outcome(rel, id, wf, predicted);
        awaited_outcomes.push_back(typed ? typed_exp : predicted);
    endtask

    // random sender gap: mostly none or short, a few long
    task automatic idle_gap(input bit steady);
        int n;
        int roll;
        if (steady)
            return;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            n = 0;
        else if (roll < 90)
            n = $urandom_range(1, 3);
        else if (roll < 98)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // capacity write only once every result is back and the block is idle
    task automatic write_capacity(input cap_t v);
        start <= 1'b0;
        while (awaited_outcomes.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cap  = fold_capacity(v);
    endtask

    // mostly ids that are allocated (the top one now and then), some free, some negative
    function automatic id_t release_target();
        int roll;
        int base;
        roll = $urandom_range(0, 99);
        if (roll < 10 && top_id >= 0)
            return top_id;
        if (roll < 70)
        begin
            base = $urandom_range(0, MAX_PAGES - 1);
            for (int k = 0; k < MAX_PAGES; k++)
                if (used_map[(base + k) % MAX_PAGES])
                    return id_t'((base + k) % MAX_PAGES);
        end
        if (roll < 85)
            return id_t'($urandom_range(0, MAX_PAGES - 1));
        if (roll < 95)
            return id_t'(-int'($urandom_range(1, MAX_PAGES)));
        return id_t'($urandom_range(0, 2047));
    endfunction

    task automatic random_item(input int alloc_pct, input bit steady);
        logic rel;
        logic wf;
        id_t  id;
        rel = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_RELEASE;
        wf  = ($urandom_range(0, 9) == 0);
        // page_id is ignored on allocate but still gets random bits
        id  = (rel == MODE_RELEASE) ? release_target() : id_t'($urandom_range(0, 2047));
        send_request(rel, id, wf, 1'b0, '0);
        idle_gap(steady);
    endtask

    // result side: every done strobe is checked against the oldest outstanding transaction
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (awaited_outcomes.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                oldest_outcome = awaited_outcomes.pop_front();
                if (ok !== oldest_outcome.ok)
                    report_mismatch($sformatf("ok: got %0b, want %0b",
                                              ok, oldest_outcome.ok));
                if (granted_id !== oldest_outcome.granted)
                    report_mismatch($sformatf("granted_id: got %0d, want %0d",
                                              granted_id, oldest_outcome.granted));
                if (highest_allocated !== oldest_outcome.highest)
                    report_mismatch($sformatf("highest_allocated: got %0d, want %0d",
                                              highest_allocated, oldest_outcome.highest));
                if (capacity !== oldest_outcome.cap)
                    report_mismatch($sformatf("capacity: got %0d, want %0d",
                                              capacity, oldest_outcome.cap));
            end
        end
    end

    // watchdog: too long without a request or result transaction ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int   sent;
        int   phase;
        int   len;
        int   alloc_pct;
        bit   steady;
        cap_t cap_value;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        start        <= 1'b0;
        mode         <= MODE_ALLOC;
        page_id      <= '0;
        write_failed <= 1'b0;

        // predicted state after reset
        used_map = '0;
        cur_cap  = fold_capacity(pia_pkg::CapReset);
        top_id   = NO_ID;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
                write_capacity(cap_t'(DIRECTED_ROWS[r].id));
            else
            begin
                send_request(DIRECTED_ROWS[r].rel, DIRECTED_ROWS[r].id, DIRECTED_ROWS[r].wf,
                             DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);
                idle_gap(1'b0);
            end
        end

        // random phases, each under its own capacity setting and mix
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase % 6)
                0: cap_value = cap_t'(1);
                1: cap_value = cap_t'(2047);
                2: cap_value = '0;
                3: cap_value = cap_t'(MAX_PAGES);
                default: cap_value = cap_t'($urandom_range(0, 2047));
            endcase
            write_capacity(cap_value);
            steady = ($urandom_range(0, 3) == 0);
            // each phase draws its own share of allocates, from 25 to 85 percent
            alloc_pct = $urandom_range(25, 85);
            len = $urandom_range(30, 70);
            repeat (len) random_item(alloc_pct, steady);
            sent += len;
            phase++;
        end

        start <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pia_pkg.sv
rtl/pia_ctrl.sv
rtl/pia_dp.sv
rtl/page_id_allocator.sv
bench/page_id_allocator_test.sv
